### rtl/bfsa_pkg.sv
package bfsa_pkg;

    localparam int BITS_DEF    = 4096;
    localparam int BIT_IDX_W   = 12;
    localparam int BYTE_IDX_W  = 9;
    localparam int BYTE_W      = 8;
    localparam int LIM_W       = 13;
    localparam int SLOT_W      = 13;
    localparam int CNT_W       = 13;
    // Byte counter of a scan: holds ceil(limit / 8) for a 13-bit limit.
    localparam int SCAN_CW     = 11;
    // Widest byte address, reached at the largest slot count of 65536.
    localparam int MEM_AW_MAX  = 13;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;

    localparam logic [LIM_W-1:0]     VALID_BITS_RST  = 13'd4096;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_BITS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE = 4'd1;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_LOAD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  wr_en;
        logic [MEM_AW_MAX-1:0] wr_addr;
        logic [BYTE_W-1:0]     wr_data;
        logic                  rd_en;
        logic [MEM_AW_MAX-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot_number;
        logic [CNT_W-1:0]  free_count;
    } t_result;

endpackage

### rtl/bfsa_mem.sv
module bfsa_mem
    import bfsa_pkg::*;
#(
    parameter int DEPTH = (BITS_DEF + 7) / 8,
    parameter int AW    = 9
) (
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/bfsa_ctrl.sv
module bfsa_ctrl
    import bfsa_pkg::*;
#(
    parameter int BITS  = BITS_DEF,
    parameter int DEPTH = (BITS_DEF + 7) / 8,
    parameter int AW    = 9
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_cmd,
    input  logic [BIT_IDX_W-1:0]  i_bit_index,
    input  logic [BYTE_IDX_W-1:0] i_byte_index,
    input  logic [BYTE_W-1:0]     i_byte_value,
    input  logic [LIM_W-1:0]      i_lim,
    input  logic                  i_base,
    output logic                  o_res_vld,
    input  logic                  i_res_rdy,
    output t_result               o_res,
    output t_mem_req              o_mem_req,
    input  logic [BYTE_W-1:0]     i_rd_data
);

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [2:0]            r_bit, n_bit;
    logic [BYTE_IDX_W-1:0] r_mark_addr, n_mark_addr;
    logic [SCAN_CW-1:0]    r_issue, n_issue;
    logic                  r_chk_vld, n_chk_vld;
    logic [SCAN_CW-1:0]    r_chk_idx, n_chk_idx;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    logic                  r_found, n_found;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]      r_count, n_count;

    t_cmd                  w_cmd;
    logic                  w_accept;
    logic                  w_mark_ok;
    logic                  w_load_ok;
    logic                  w_clr_last;
    logic [SCAN_CW-1:0]    w_nb;
    logic                  w_issue;
    logic [LIM_W:0]        w_rem;
    logic [BYTE_W-1:0]     w_mask;
    logic [BYTE_W-1:0]     w_free;
    logic [2:0]            w_pos;
    logic [3:0]            w_pop;
    logic                  w_last;
    logic                  w_hit;

    assign w_cmd      = t_cmd'(i_cmd);
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_mark_ok  = 32'(i_bit_index) < BITS;
    assign w_load_ok  = 32'(i_byte_index) < DEPTH;
    assign w_clr_last = (r_clr_addr == AW'(DEPTH - 1));

    // Number of bytes that hold slots below the limit.
    assign w_nb    = SCAN_CW'((14'(i_lim) + 14'd7) >> 3);
    assign w_issue = (r_issue < w_nb);

    // Slots left in the byte under check; only its lowest ones count when fewer than 8.
    assign w_rem  = 14'(i_lim) - {r_chk_idx, 3'b000};
    assign w_mask = (w_rem >= 14'd8) ? 8'hFF : ~(8'hFF << w_rem[2:0]);
    assign w_free = ~i_rd_data & w_mask;

    always_comb begin
        w_pos = 3'd0;
        w_pop = 4'd0;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            if (w_free[k]) begin
                w_pos = 3'(k);
            end
        end
        for (int k = 0; k < BYTE_W; k++) begin
            w_pop = w_pop + 4'(w_free[k]);
        end
    end

    assign w_last = r_chk_vld && (r_chk_idx == w_nb - 11'd1);
    assign w_hit  = r_chk_vld && (r_cmd == CMD_ALLOC) && (w_free != 8'd0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_ALLOC, CMD_COUNT: begin
                            n_state = (w_nb == 11'd0) ? ST_DONE : ST_SCAN;
                        end
                        CMD_MARK: begin
                            n_state = w_mark_ok ? ST_MARK : ST_DONE;
                        end
                        CMD_LOAD: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_MARK: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_rdy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory requests and result handshake.
    always_comb begin
        o_mem_req = '0;
        o_res_vld = (r_state == ST_DONE);
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = MEM_AW_MAX'(r_clr_addr);
                o_mem_req.wr_data = 8'd0;
            end
            ST_IDLE: begin
                if (w_accept && (w_cmd == CMD_MARK) && w_mark_ok) begin
                    o_mem_req.rd_en   = 1'b1;
                    o_mem_req.rd_addr = MEM_AW_MAX'(i_bit_index[BIT_IDX_W-1:3]);
                end
                if (w_accept && (w_cmd == CMD_LOAD) && w_load_ok) begin
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = MEM_AW_MAX'(i_byte_index);
                    o_mem_req.wr_data = i_byte_value;
                end
            end
            ST_SCAN: begin
                o_mem_req.rd_en   = w_issue;
                o_mem_req.rd_addr = MEM_AW_MAX'(r_issue);
                if (w_hit) begin
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = MEM_AW_MAX'(r_chk_idx);
                    o_mem_req.wr_data = i_rd_data | (8'd1 << w_pos);
                end
            end
            ST_MARK: begin
                o_mem_req.wr_en   = 1'b1;
                o_mem_req.wr_addr = MEM_AW_MAX'(r_mark_addr);
                o_mem_req.wr_data = i_rd_data | (8'd1 << r_bit);
            end
            ST_DONE: begin
                o_mem_req = '0;
            end
            default: begin
                o_mem_req = '0;
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_cmd       = r_cmd;
        n_bit       = r_bit;
        n_mark_addr = r_mark_addr;
        n_issue     = r_issue;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_clr_addr  = r_clr_addr;
        n_found     = r_found;
        n_slot      = r_slot;
        n_count     = r_count;
        if (r_state == ST_CLEAR) begin
            n_clr_addr = r_clr_addr + AW'(1);
        end
        if (w_accept) begin
            n_cmd       = w_cmd;
            n_bit       = i_bit_index[2:0];
            n_mark_addr = i_bit_index[BIT_IDX_W-1:3];
            n_issue     = '0;
            n_found     = 1'b0;
            n_slot      = '0;
            n_count     = '0;
        end
        if (r_state == ST_SCAN) begin
            n_issue   = r_issue + SCAN_CW'(w_issue);
            n_chk_vld = w_issue;
            n_chk_idx = r_issue;
            if (r_chk_vld && (r_cmd == CMD_COUNT)) begin
                n_count = r_count + CNT_W'(w_pop);
            end
            if (w_hit) begin
                n_found = 1'b1;
                n_slot  = SLOT_W'({r_chk_idx, w_pos} + 14'(i_base));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_chk_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_chk_vld  <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_bit       <= n_bit;
        r_mark_addr <= n_mark_addr;
        r_issue     <= n_issue;
        r_chk_idx   <= n_chk_idx;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_count     <= n_count;
    end

    assign o_res.found       = r_found;
    assign o_res.slot_number = r_slot;
    assign o_res.free_count  = r_count;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_in_stall)
        else $error("item accepted during the clearing pass");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("second item accepted before the first finished");

    a_scan_write_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && o_mem_req.wr_en) |-> (r_cmd == CMD_ALLOC))
        else $error("store written during a free count");

    a_check_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_chk_vld) |-> (r_chk_idx < w_nb))
        else $error("byte checked beyond the slot limit");
`endif

endmodule

### rtl/bitmap_free_slot_allocator.sv
// First-fit slot allocator over a bitmap of BITS slots, one bit per slot, held as bytes in
// an on-chip memory (slot s is bit s%8 of byte s/8; a set bit is a used slot). Commands:
// 0 allocates the lowest free slot below the valid count and reports found plus the slot
// number offset by number_base; 1 marks a slot used; 2 counts the free slots below the
// valid count; 3 loads one bitmap byte. Every command gives exactly one result beat;
// slot_number and free_count are zero where the command does not produce them. After
// reset the block clears the memory one byte per cycle and stalls its input until that
// is done; configuration writes are taken at any time but must only be made while no
// command is in flight. Items are handled one at a time. Allocate and count read the
// memory one byte per cycle up to the limit, the smaller of valid_bits and BITS;
// allocate stops at the first byte with a free slot. Mark reads its byte, then writes
// it back with the bit set; load writes its byte directly. A finished result sits in an
// output register, so the next command can be accepted while that result is still
// stalled downstream.
module bitmap_free_slot_allocator
    import bfsa_pkg::*;
#(
    parameter int BITS = BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_cmd,
    input  logic [BIT_IDX_W-1:0]  i_bit_index,
    input  logic [BYTE_IDX_W-1:0] i_byte_index,
    input  logic [BYTE_W-1:0]     i_byte_value,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output logic [SLOT_W-1:0]     o_slot_number,
    output logic [CNT_W-1:0]      o_free_count
);

    localparam int DEPTH = (BITS + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LIM_W-1:0]  r_valid_bits;
    logic              r_number_base;
    logic              r_out_vld;
    t_result           r_out;

    logic [LIM_W-1:0]  w_lim;
    logic              w_res_vld;
    logic              w_res_rdy;
    t_result           w_res;
    t_mem_req          w_mem_req;
    logic [BYTE_W-1:0] w_rd_data;
    logic              w_cfg_wr;

    // Configuration registers. Writes to indexes beyond the two registers are dropped.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits  <= VALID_BITS_RST;
            r_number_base <= 1'b0;
        end else if (w_cfg_wr) begin
            if (i_cfg_index == CFG_VALID_BITS) begin
                r_valid_bits <= i_cfg_data;
            end
            if (i_cfg_index == CFG_NUMBER_BASE) begin
                r_number_base <= i_cfg_data[0];
            end
        end
    end

    // A valid count above the bitmap size saturates at the size.
    assign w_lim = (32'(r_valid_bits) > BITS) ? LIM_W'(BITS) : r_valid_bits;

    bfsa_ctrl #(
        .BITS  (BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_bit_index  (i_bit_index),
        .i_byte_index (i_byte_index),
        .i_byte_value (i_byte_value),
        .i_lim        (w_lim),
        .i_base       (r_number_base),
        .o_res_vld    (w_res_vld),
        .i_res_rdy    (w_res_rdy),
        .o_res        (w_res),
        .o_mem_req    (w_mem_req),
        .i_rd_data    (w_rd_data)
    );

    bfsa_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    // Output register: takes a new result when empty or when its beat leaves this cycle.
    assign w_res_rdy = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_rdy) begin
            r_out_vld <= w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_rdy && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_found       = r_out.found;
    assign o_slot_number = r_out.slot_number;
    assign o_free_count  = r_out.free_count;

endmodule
